// ----- hdl/ipv6txt_pkg.sv -----
// Shared types, constants and a helper function for the IPv6 address text formatter.
package ipv6txt_pkg;

  localparam int NumGroups = 8;
  localparam int GroupW    = 16;
  localparam int CharW     = 7;

  localparam logic [CharW-1:0] ChColon = 7'h3a;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChAlpha = 7'h57;

  typedef logic [GroupW-1:0] group_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last;
  } dp_status_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = ChZero + wide;
    end else begin
      hex_char = ChAlpha + wide;
    end
  endfunction

endpackage

// ----- hdl/ipv6txt_datapath.sv -----
// Datapath: group registers, zero-run search, character pointer and output register.
module ipv6txt_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  ipv6txt_pkg::dp_cmd_t      cmd,
  output ipv6txt_pkg::dp_status_t   status,
  input  logic [63:0]               addr_high,
  input  logic [63:0]               addr_low,
  output logic                      text_valid,
  input  logic                      text_ready,
  output logic [6:0]                text_char,
  output logic                      last_char
);
  import ipv6txt_pkg::*;

  localparam logic [1:0] PH_SEP   = 2'd0;
  localparam logic [1:0] PH_GAP1  = 2'd1;
  localparam logic [1:0] PH_GAP2  = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  group_t     grp [NumGroups];
  logic [2:0] best_start;
  logic       gap;
  logic [3:0] gap_end;
  logic [2:0] gi;
  logic [1:0] ni;
  logic [1:0] phase;

  logic [2:0] scan_start;
  logic [3:0] scan_len;
  logic [2:0] run_start;
  logic [3:0] run_len;
  logic       scan_gap;

  group_t           cur;
  logic [1:0]       skip;
  logic [1:0]       k;
  logic [3:0]       nib;
  logic [CharW-1:0] ch;
  logic             is_last;
  logic [2:0]       nxt;
  logic [1:0]       nxt_phase;

  always_comb begin
    run_start  = '0;
    run_len    = '0;
    scan_start = '0;
    scan_len   = '0;
    for (int i = 0; i < NumGroups; i++) begin
      if (grp[i] == '0) begin
        if (run_len == '0) begin
          run_start = 3'(i);
        end
        run_len = run_len + 4'd1;
        if (run_len > scan_len) begin
          scan_len   = run_len;
          scan_start = run_start;
        end
      end else begin
        run_len = '0;
      end
    end
    scan_gap = (scan_len >= 4'd2);
  end

  always_comb begin
    cur = grp[gi];
    if (cur[15:12] != 4'd0) begin
      skip = 2'd0;
    end else if (cur[11:8] != 4'd0) begin
      skip = 2'd1;
    end else if (cur[7:4] != 4'd0) begin
      skip = 2'd2;
    end else begin
      skip = 2'd3;
    end
    k = (ni > skip) ? ni : skip;
    case (k)
      2'd0:    nib = cur[15:12];
      2'd1:    nib = cur[11:8];
      2'd2:    nib = cur[7:4];
      default: nib = cur[3:0];
    endcase
    ch = (phase == PH_DIGIT) ? hex_char(nib) : ChColon;
    is_last = ((phase == PH_GAP2) && (gap_end == 4'd8)) ||
              ((phase == PH_DIGIT) && (k == 2'd3) && (gi == 3'd7));
    nxt = gi + 3'd1;
    if (gap && (nxt == best_start)) begin
      nxt_phase = PH_GAP1;
    end else if ((nxt != 3'd0) && !(gap && ({1'b0, nxt} == gap_end))) begin
      nxt_phase = PH_SEP;
    end else begin
      nxt_phase = PH_DIGIT;
    end
  end

  assign status.slot_free = !text_valid || text_ready;
  assign status.last      = is_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NumGroups / 2; i++) begin
        grp[i]                 <= addr_high[63 - GroupW * i -: GroupW];
        grp[i + NumGroups / 2] <= addr_low[63 - GroupW * i -: GroupW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      best_start <= scan_start;
      gap        <= scan_gap;
      gap_end    <= {1'b0, scan_start} + scan_len;
      gi         <= '0;
      ni         <= '0;
      phase      <= (scan_gap && (scan_start == 3'd0)) ? PH_GAP1 : PH_DIGIT;
    end else if (cmd.step) begin
      case (phase)
        PH_SEP: begin
          phase <= PH_DIGIT;
          ni    <= '0;
        end
        PH_GAP1: begin
          phase <= PH_GAP2;
        end
        PH_GAP2: begin
          gi    <= gap_end[2:0];
          ni    <= '0;
          phase <= PH_DIGIT;
        end
        default: begin
          if (k == 2'd3) begin
            gi    <= nxt;
            ni    <= '0;
            phase <= nxt_phase;
          end else begin
            ni <= k + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (cmd.step) begin
      text_valid <= 1'b1;
    end else if (text_ready) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      text_char <= ch;
      last_char <= is_last;
    end
  end

endmodule

// ----- hdl/ipv6txt_ctrl.sv -----
// Controller: sequences load, zero-run scan and character emission for one address.
module ipv6txt_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     addr_valid,
  output logic                     addr_ready,
  output ipv6txt_pkg::dp_cmd_t     cmd,
  input  ipv6txt_pkg::dp_status_t  status
);
  import ipv6txt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign addr_ready = (state == ST_IDLE);
  assign cmd.load   = addr_valid && (state == ST_IDLE);
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.step   = (state == ST_EMIT) && status.slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (addr_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.step && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_no_step_outside_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (state == ST_EMIT))
    else $error("character step outside emit state");

  a_load_goes_to_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SCAN) && cmd.scan)
    else $error("accepted item not followed by scan");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.last) |=> (state == ST_IDLE) && addr_ready)
    else $error("controller did not return to idle after last character");
`endif

endmodule

// ----- hdl/ipv6_address_to_text.sv -----
// Top level of the IPv6 address to canonical text formatter.
//
// Usage: an address is offered on addr_high/addr_low with addr_valid and is
// accepted when addr_ready is also high. Group 0 is addr_high[63:48] and
// group 7 is addr_low[15:0]. The text comes out one ASCII character per item
// on text_char with text_valid/text_ready, and last_char marks the final
// character of each address.
// The groups are loaded when the address is accepted; the controller then
// finds the longest zero run in its scan state before the emitter starts.
// The emitter produces one character per cycle while the output register is
// free, that is while text_valid is low or text_ready is high.
// addr_ready is high only while no address is being formatted; it returns in
// the cycle after the last character enters the output register.
// A stalled receiver holds the output register and pauses the emitter; no
// character is lost or repeated. Reset returns the controller to idle and
// clears text_valid; no other state survives between addresses.
module ipv6_address_to_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        addr_valid,
  output logic        addr_ready,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  output logic        text_valid,
  input  logic        text_ready,
  output logic [6:0]  text_char,
  output logic        last_char
);
  import ipv6txt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ipv6txt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .addr_valid (addr_valid),
    .addr_ready (addr_ready),
    .cmd        (cmd),
    .status     (status)
  );

  ipv6txt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .addr_high  (addr_high),
    .addr_low   (addr_low),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_char  (text_char),
    .last_char  (last_char)
  );

endmodule

// ----- tb/ipv6_address_to_text_tb.sv -----
// Self-checking testbench for the IPv6 address to canonical text formatter.
module ipv6_address_to_text_tb;
  import ipv6txt_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int RandomAddrs = 380;
  localparam logic [CharW-1:0] AsciiLowerA = 7'h61;

  typedef struct {
    logic [CharW-1:0] ch;
    logic last;
  } text_item_t;

  typedef struct {
    logic [127:0] addr;
    bit drain_first;
  } addr_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic addr_valid = 1'b0;
  logic addr_ready;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic text_valid;
  logic text_ready = 1'b0;
  logic [CharW-1:0] text_char;
  logic last_char;

  addr_item_t pending_addrs[$];
  text_item_t expected_chars[$];
  logic addr_fire = 1'b0;
  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_timer = 0;
  int stall_mode = 0;
  logic [15:0] stall_pattern = 16'h0001;

  ipv6_address_to_text dut (
    .clk(clk),
    .rst(rst),
    .addr_valid(addr_valid),
    .addr_ready(addr_ready),
    .addr_high(addr_high),
    .addr_low(addr_low),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text_char(text_char),
    .last_char(last_char)
  );

  always #5 clk = ~clk;

  function automatic logic [CharW-1:0] nibble_ascii(input logic [3:0] n);
    if (n < 4'd10) begin
      return ChZero + CharW'(n);
    end
    return AsciiLowerA + CharW'(n - 4'd10);
  endfunction

  function automatic void predict_text(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] whole;
    group_t grp[NumGroups];
    text_item_t chars[$];
    int run_len;
    int run_start;
    int best_len;
    int best_start;
    int gap_end;
    int lead;
    bit gap;
    whole = {hi, lo};
    run_len = 0;
    run_start = 0;
    best_len = 0;
    best_start = 0;
    for (int i = 0; i < NumGroups; i++) begin
      grp[i] = whole[127 - GroupW * i -: GroupW];
      if (grp[i] == '0) begin
        if (run_len == 0) begin
          run_start = i;
        end
        run_len++;
        if (run_len > best_len) begin
          best_len = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 0;
      end
    end
    gap = best_len >= 2;
    gap_end = best_start + best_len;
    for (int i = 0; i < NumGroups; i++) begin
      if (gap && i == best_start) begin
        chars.push_back('{ChColon, 1'b0});
        chars.push_back('{ChColon, 1'b0});
      end else if (!(gap && i > best_start && i < gap_end)) begin
        if (i != 0 && !(gap && i == gap_end)) begin
          chars.push_back('{ChColon, 1'b0});
        end
        lead = 0;
        while (lead < 3 && grp[i][15 - 4 * lead -: 4] == 4'h0) begin
          lead++;
        end
        for (int k = lead; k < 4; k++) begin
          chars.push_back('{nibble_ascii(grp[i][15 - 4 * k -: 4]), 1'b0});
        end
      end
    end
    chars[chars.size() - 1].last = 1'b1;
    foreach (chars[j]) begin
      expected_chars.push_back(chars[j]);
    end
  endfunction

  function automatic group_t random_group();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4: return group_t'($urandom_range(1, 'hf));
      5: return group_t'($urandom_range('h10, 'hff));
      6: return group_t'($urandom_range('h100, 'hfff));
      7: return 16'hffff;
      default: return group_t'($urandom);
    endcase
  endfunction

  function automatic void queue_address(input logic [127:0] addr, input bit drain_first);
    pending_addrs.push_back('{addr, drain_first});
  endfunction

  always @(negedge clk) begin
    addr_item_t item;
    if (!rst && (!addr_valid || addr_fire)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        addr_valid <= 1'b0;
      end else if (pending_addrs.size() != 0 &&
                   !(pending_addrs[0].drain_first && expected_chars.size() != 0)) begin
        item = pending_addrs.pop_front();
        addr_high <= item.addr[127:64];
        addr_low <= item.addr[63:0];
        addr_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        addr_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_pattern <= 16'($urandom | 1);
      stall_timer <= $urandom_range(20, 200);
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: text_ready <= 1'b1;
      1: text_ready <= 1'($urandom_range(0, 1));
      2: text_ready <= ($urandom_range(0, 3) == 0);
      default: text_ready <= stall_pattern[0];
    endcase
  end

  always @(posedge clk) begin
    text_item_t want;
    if (rst) begin
      addr_fire <= 1'b0;
    end else begin
      addr_fire <= addr_valid && addr_ready;
      if (addr_valid && addr_ready) begin
        predict_text(addr_high, addr_low);
      end
      if (text_valid && text_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item, expected none, got char %h last %b",
                   $time, text_char, last_char);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (text_char !== want.ch) begin
            $display("%0t: text_char expected %h got %h", $time, want.ch, text_char);
            error_count++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char expected %b got %b", $time, want.last, last_char);
            error_count++;
          end
        end
      end
      if ((addr_valid && addr_ready) || (text_valid && text_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no item accepted for %0d cycles", $time, IdleLimit);
        $display("** ipv6_address_to_text: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [127:0] addr;
    queue_address(128'h0, 1'b1);
    queue_address({8{16'hffff}}, 1'b0);
    queue_address(128'h1, 1'b0);
    queue_address(128'h0001_0000_0000_0000_0000_0000_0000_0000, 1'b0);
    queue_address(128'h0001_0000_0001_0001_0001_0001_0001_0001, 1'b0);
    queue_address(128'h0001_0000_0000_0001_0000_0000_0001_0001, 1'b0);
    queue_address(128'h0001_0000_0000_0001_0000_0000_0000_0001, 1'b0);
    queue_address(128'h0000_0000_0001_0001_0001_0001_0001_0001, 1'b0);
    queue_address(128'h0001_0001_0001_0001_0001_0001_0000_0000, 1'b0);
    queue_address(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 1'b0);
    queue_address(128'h000f_00f0_0f00_f000_000a_00b0_0c00_d000, 1'b0);
    queue_address(128'h0000_0001_0000_0001_0000_0001_0000_0001, 1'b0);
    queue_address(128'h2001_0db8_0000_0000_0000_ff00_0042_8329, 1'b0);
    queue_address(128'hfe80_0000_0000_0000_0202_b3ff_fe1e_8329, 1'b0);
    queue_address(128'h0000_0000_0000_0000_0000_ffff_c000_0280, 1'b0);
    queue_address(128'h8000_0000_0000_0000_0000_0000_0000_0000, 1'b0);
    queue_address(128'h0000_0001_0000_0000_0000_0000_0000_0001, 1'b0);
    queue_address(128'h0001_0000_0000_0000_0001_0000_0000_0000, 1'b0);
    queue_address(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_0000, 1'b0);
    queue_address(128'h0000_ffff_ffff_ffff_ffff_ffff_ffff_ffff, 1'b0);
    for (int n = 0; n < RandomAddrs; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        addr = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        for (int i = 0; i < NumGroups; i++) begin
          addr[127 - GroupW * i -: GroupW] = random_group();
        end
      end
      queue_address(addr, (n % 60) == 59);
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_addrs.size() != 0 || addr_valid) begin
      @(negedge clk);
    end
    while (expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (45) @(negedge clk);
    if (error_count == 0) begin
      $display("** ipv6_address_to_text: PASSED **");
    end else begin
      $display("** ipv6_address_to_text: FAILED **");
    end
    $finish;
  end

endmodule
